// File: rtl/core/dfp_pkg.sv
// ----------------------------------------------------------------------------
// dfp_pkg: shared types and constants of the decimal fraction parser
// Character codes, result widths, status codes and the flag group that is
// passed from the character scanner to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dfp_pkg;

  localparam int CH_W     = 8;
  localparam int VALUE_W  = 51;
  localparam int STATUS_W = 3;

  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_PLUS  = 3'd1,
    ST_BAD   = 3'd2,
    ST_ZERO  = 3'd3,
    ST_NONE  = 3'd4,
    ST_OVF   = 3'd5
  } status_t;

  typedef struct packed {
    logic negative;
    logic seen_digit;
    logic stopped;
    logic plus_seen;
    logic overflowed;
  } flags_t;

  // Power of ten in 64 bits, wrapping as unsigned arithmetic does.
  // Only ever evaluated on constants.
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dfp_char_if.sv
// ----------------------------------------------------------------------------
// dfp_char_if: character channel
// One ASCII character per request, with a flag on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfp_char_if;
  logic                      valid;
  logic                      ready;
  logic [dfp_pkg::CH_W-1:0]  ch;
  logic                      last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dfp_result_if.sv
// ----------------------------------------------------------------------------
// dfp_result_if: result channel
// One parsed fixed-point value and its status per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfp_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [dfp_pkg::VALUE_W-1:0]  value;
  logic [dfp_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/decimal_fraction_parser.sv
// ----------------------------------------------------------------------------
// decimal_fraction_parser: ASCII decimal string to fixed-point converter
// Parses a signed decimal number, one character per request, into its value
// times 10^FRAC_DIGITS together with a status code.
// ----------------------------------------------------------------------------
// Usage:
// The chars channel takes one ASCII character per request; last marks the
// final character of a string. One request leaves on the results channel
// for every string: value (two's complement, 51 bits) and status.
// Characters are taken at one per cycle, back to back, with no gap needed
// between strings. The scanner state is a single set of registers updated by each
// character; a finished string passes through a snapshot register and then
// the result register, which holds the result until the receiver takes it.
// If the receiver stalls, the result is held and the snapshot register takes
// the next finished string; once that register is occupied as well, no
// character at all is taken until the receiver takes the held result.
// Synchronous reset clears the parse state and empties both registers; the
// block takes characters from the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_fraction_parser #(
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic    clk,
  input  wire logic    rst,
  dfp_char_if.sink     chars,
  dfp_result_if.source results
);

  localparam int FW = $clog2(dfp_pkg::pow10(FRAC_DIGITS));

  logic                          snap_valid;
  logic                          snap_ready;
  logic [dfp_pkg::VALUE_W-1:0]   snap_int;
  logic [FW-1:0]                 snap_frac;
  dfp_pkg::flags_t               snap_flags;

  dfp_scan #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_int   (snap_int),
    .snap_frac  (snap_frac),
    .snap_flags (snap_flags)
  );

  dfp_result #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_int   (snap_int),
    .snap_frac  (snap_frac),
    .snap_flags (snap_flags),
    .results    (results)
  );

endmodule

`default_nettype wire

// File: rtl/core/dfp_scan.sv
// ----------------------------------------------------------------------------
// dfp_scan: character scanner
// Holds the parse state of the current string and updates it on every
// accepted character. On the final character the finished state is loaded
// into a snapshot register for the result stage and the parse state clears.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_scan #(
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  dfp_char_if.sink                           chars,
  output logic                               snap_valid,
  input  wire logic                          snap_ready,
  output logic [dfp_pkg::VALUE_W-1:0]        snap_int,
  output logic [$clog2(dfp_pkg::pow10(FRAC_DIGITS))-1:0] snap_frac,
  output dfp_pkg::flags_t                    snap_flags
);

  localparam int VW = dfp_pkg::VALUE_W;
  localparam int IW = $clog2(dfp_pkg::pow10(INT_DIGITS));
  localparam int FW = $clog2(dfp_pkg::pow10(FRAC_DIGITS));
  localparam int CW = $clog2(FRAC_DIGITS + 1);
  localparam int WN = 1 << CW;

  localparam logic [IW+3:0]   INT_LIM = (IW+4)'(dfp_pkg::pow10(INT_DIGITS) - 64'd1);
  localparam logic [VW-1:0]   FRAC_SCALE = VW'(dfp_pkg::pow10(FRAC_DIGITS));
  localparam logic [CW-1:0]   FRAC_MAX = CW'(FRAC_DIGITS);

  // Place value of the next fraction digit, indexed by the digits taken so far.
  logic [FW-1:0] weight [WN];

  for (genvar k = 0; k < WN; k++) begin : g_weight
    assign weight[k] = (k < FRAC_DIGITS) ? FW'(dfp_pkg::pow10(FRAC_DIGITS - 1 - k)) : '0;
  end

  logic            at_first;
  logic            seen_dot;
  dfp_pkg::flags_t flags;
  logic [IW-1:0]   int_accum;
  logic [VW-1:0]   int_scaled;
  logic [FW-1:0]   frac_accum;
  logic [CW-1:0]   frac_count;

  logic            seen_dot_next;
  dfp_pkg::flags_t flags_next;
  logic [IW-1:0]   int_accum_next;
  logic [VW-1:0]   int_scaled_next;
  logic [FW-1:0]   frac_accum_next;
  logic [CW-1:0]   frac_count_next;

  logic            accept;
  logic            is_digit;
  logic [3:0]      digit;
  logic [IW+3:0]   int_trial;

  assign chars.ready = !snap_valid || snap_ready;
  assign accept      = chars.valid && chars.ready;

  assign is_digit  = (chars.ch >= dfp_pkg::CH_ZERO) && (chars.ch <= dfp_pkg::CH_NINE);
  assign digit     = chars.ch[3:0];
  assign int_trial = ({4'd0, int_accum} << 3) + ({4'd0, int_accum} << 1) + (IW+4)'(digit);

  always_comb begin
    seen_dot_next   = seen_dot;
    flags_next      = flags;
    int_accum_next  = int_accum;
    int_scaled_next = int_scaled;
    frac_accum_next = frac_accum;
    frac_count_next = frac_count;
    if (!flags.stopped) begin
      if (is_digit) begin
        flags_next.seen_digit = 1'b1;
        if (!seen_dot) begin
          if (!flags.overflowed) begin
            if (int_trial > INT_LIM) begin
              flags_next.overflowed = 1'b1;
              int_accum_next        = INT_LIM[IW-1:0];
            end else begin
              int_accum_next  = int_trial[IW-1:0];
              int_scaled_next = (int_scaled << 3) + (int_scaled << 1)
                                + VW'(digit) * FRAC_SCALE;
            end
          end
        end else if (frac_count < FRAC_MAX) begin
          frac_accum_next = frac_accum + FW'(digit) * weight[frac_count];
          frac_count_next = frac_count + CW'(1);
        end
      end else if (at_first && chars.ch == dfp_pkg::CH_MINUS) begin
        flags_next.negative = 1'b1;
      end else if (at_first && chars.ch == dfp_pkg::CH_PLUS) begin
        flags_next.plus_seen = 1'b1;
      end else if (!at_first && chars.ch == dfp_pkg::CH_DOT && !seen_dot) begin
        seen_dot_next = 1'b1;
      end else begin
        flags_next.stopped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first   <= 1'b1;
      seen_dot   <= 1'b0;
      flags      <= '0;
      int_accum  <= '0;
      int_scaled <= '0;
      frac_accum <= '0;
      frac_count <= '0;
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= (accept && chars.last) || (snap_valid && !snap_ready);
      if (accept) begin
        if (chars.last) begin
          // The string ends here: hand the finished state on and start afresh.
          at_first   <= 1'b1;
          seen_dot   <= 1'b0;
          flags      <= '0;
          int_accum  <= '0;
          int_scaled <= '0;
          frac_accum <= '0;
          frac_count <= '0;
        end else begin
          at_first   <= 1'b0;
          seen_dot   <= seen_dot_next;
          flags      <= flags_next;
          int_accum  <= int_accum_next;
          int_scaled <= int_scaled_next;
          frac_accum <= frac_accum_next;
          frac_count <= frac_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.last) begin
      snap_int   <= int_scaled_next;
      snap_frac  <= frac_accum_next;
      snap_flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dfp_result.sv
// ----------------------------------------------------------------------------
// dfp_result: result stage
// Combines the scaled integer and fraction parts, applies saturation and the
// sign, ranks the status conditions and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_result #(
  parameter int INT_DIGITS  = 9,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          snap_valid,
  output logic                               snap_ready,
  input  wire logic [dfp_pkg::VALUE_W-1:0]   snap_int,
  input  wire logic [$clog2(dfp_pkg::pow10(FRAC_DIGITS))-1:0] snap_frac,
  input  wire dfp_pkg::flags_t               snap_flags,
  dfp_result_if.source                       results
);

  localparam int VW = dfp_pkg::VALUE_W;
  localparam logic [VW-1:0] MAX_MAG =
    VW'(dfp_pkg::pow10(INT_DIGITS + FRAC_DIGITS) - 64'd1);

  logic             take;
  logic             is_zero;
  logic [VW-1:0]    mag;
  logic [VW-1:0]    value_next;
  dfp_pkg::status_t status_next;

  assign snap_ready = !results.valid || results.ready;
  assign take       = snap_valid && snap_ready;

  // The scaled integer part is zero only when the integer part is.
  assign is_zero    = !snap_flags.overflowed && (snap_int == '0) && (snap_frac == '0);
  assign mag        = snap_flags.overflowed ? MAX_MAG : snap_int + VW'(snap_frac);
  assign value_next = snap_flags.negative ? (VW'(0) - mag) : mag;

  always_comb begin
    if (!snap_flags.seen_digit) begin
      status_next = dfp_pkg::ST_NONE;
    end else if (is_zero) begin
      status_next = dfp_pkg::ST_ZERO;
    end else if (snap_flags.stopped) begin
      status_next = dfp_pkg::ST_BAD;
    end else if (snap_flags.overflowed) begin
      status_next = dfp_pkg::ST_OVF;
    end else if (snap_flags.plus_seen) begin
      status_next = dfp_pkg::ST_PLUS;
    end else begin
      status_next = dfp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (snap_ready) begin
      results.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      results.value  <= signed'(value_next);
      results.status <= status_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dfp_checker.sv
// ----------------------------------------------------------------------------
// dfp_checker: port-level checks of the decimal fraction parser
// Watches the character and result channels and checks latency, stall
// behaviour and the value carried with the zero, no-digit, ok and plus status codes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_last,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [dfp_pkg::VALUE_W-1:0] out_value,
  input wire logic [dfp_pkg::STATUS_W-1:0]       out_status
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while the receiver stalled");

  // A result appearing on an empty output comes from a final character that
  // was taken and then passed through the snapshot and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result appeared without a final character two cycles before");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == dfp_pkg::ST_ZERO || out_status == dfp_pkg::ST_NONE)
      |-> out_value == '0)
    else $error("zero or no-digit status with a non-zero value");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == dfp_pkg::ST_OK || out_status == dfp_pkg::ST_PLUS)
      |-> out_value != '0)
    else $error("ok status with a zero value");

endmodule

bind decimal_fraction_parser dfp_checker u_dfp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .in_last    (chars.last),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.value),
  .out_status (results.status)
);

`default_nettype wire
